// ----- rtl/sapw_pkg.sv -----
// Shared types and constants for the six-axis PID wrench controller.
// Used by the configuration registers, the axis lanes and the top level.
package sapw_pkg;

  localparam int NUM_AXES    = 6;
  localparam int NUM_LINEAR  = 3;
  localparam int ERR_W       = 24;
  localparam int GAIN_W      = 32;
  localparam int LIM_W       = 31;
  localparam int OUT_W       = 32;
  localparam int ACC_W       = 32;
  localparam int FRAC_W      = 16;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;

  localparam int PP_W  = ERR_W + GAIN_W + 1;
  localparam int PI_W  = ACC_W + GAIN_W + 1;
  localparam int PD_W  = ERR_W + GAIN_W + 2;
  localparam int SUM_W = PI_W + 2;

  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_ABORT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_LINEAR    = 4'd0,
    REG_KI_LINEAR    = 4'd1,
    REG_KD_LINEAR    = 4'd2,
    REG_KP_ANGULAR   = 4'd3,
    REG_KI_ANGULAR   = 4'd4,
    REG_KD_ANGULAR   = 4'd5,
    REG_FORCE_LIMIT  = 4'd6,
    REG_TORQUE_LIMIT = 4'd7
  } reg_index_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [LIM_W-1:0]  lim;
  } gain_set_t;

  typedef struct packed {
    logic load_s1;
    logic load_s2;
    logic load_out;
    logic clear;
  } stage_ctl_t;

endpackage

// ----- rtl/sapw_cfg_regs.sv -----
// Configuration register file: gains and output limits for both axis groups.
// Depends on sapw_pkg for the register indexes and the gain set type.
module sapw_cfg_regs import sapw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output gain_set_t             linear,
  output gain_set_t             angular
);

  always_ff @(posedge clk) begin
    if (rst) begin
      linear  <= '0;
      angular <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP_LINEAR:    linear.kp   <= cfg_data[GAIN_W-1:0];
        REG_KI_LINEAR:    linear.ki   <= cfg_data[GAIN_W-1:0];
        REG_KD_LINEAR:    linear.kd   <= cfg_data[GAIN_W-1:0];
        REG_KP_ANGULAR:   angular.kp  <= cfg_data[GAIN_W-1:0];
        REG_KI_ANGULAR:   angular.ki  <= cfg_data[GAIN_W-1:0];
        REG_KD_ANGULAR:   angular.kd  <= cfg_data[GAIN_W-1:0];
        REG_FORCE_LIMIT:  linear.lim  <= cfg_data[LIM_W-1:0];
        REG_TORQUE_LIMIT: angular.lim <= cfg_data[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/sapw_axis.sv -----
// One axis lane: clamped error accumulator, previous error, the three gain
// products and the floored, saturated drive value. Depends on sapw_pkg.
module sapw_axis import sapw_pkg::*; #(
  parameter int AccLimit = 1048576
) (
  input  logic                    clk,
  input  logic                    rst,
  input  stage_ctl_t              ctl,
  input  logic signed [ERR_W-1:0] err,
  input  gain_set_t               gains,
  output logic signed [OUT_W-1:0] drive
);

  localparam logic signed [ACC_W:0] AccHi = (ACC_W+1)'(AccLimit);
  localparam logic signed [ACC_W:0] AccLo = -AccHi;

  logic signed [ACC_W-1:0] acc;
  logic signed [ERR_W-1:0] prev;
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ERR_W:0]   diff;

  logic signed [ERR_W-1:0] s1_err;
  logic signed [ACC_W-1:0] s1_acc;
  logic signed [ERR_W:0]   s1_diff;

  logic signed [PP_W-1:0]  prod_p;
  logic signed [PI_W-1:0]  prod_i;
  logic signed [PD_W-1:0]  prod_d;

  logic signed [SUM_W-1:0] total;
  logic signed [SUM_W-1:0] scaled;
  logic signed [SUM_W-1:0] lim_pos;
  logic signed [SUM_W-1:0] lim_neg;
  logic signed [SUM_W-1:0] sat;

  always_comb begin
    acc_sum = (ACC_W+1)'(acc) + (ACC_W+1)'(err);
    if (acc_sum > AccHi) begin
      acc_next = AccHi[ACC_W-1:0];
    end else if (acc_sum < AccLo) begin
      acc_next = AccLo[ACC_W-1:0];
    end else begin
      acc_next = acc_sum[ACC_W-1:0];
    end
    diff = (ERR_W+1)'(err) - (ERR_W+1)'(prev);
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      acc  <= '0;
      prev <= '0;
    end else if (ctl.load_s1) begin
      acc  <= acc_next;
      prev <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_s1) begin
      s1_err  <= err;
      s1_acc  <= acc_next;
      s1_diff <= diff;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_s2) begin
      prod_p <= PP_W'(s1_err) * PP_W'({1'b0, gains.kp});
      prod_i <= PI_W'(s1_acc) * PI_W'({1'b0, gains.ki});
      prod_d <= PD_W'(s1_diff) * PD_W'({1'b0, gains.kd});
    end
  end

  always_comb begin
    total   = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
    scaled  = total >>> FRAC_W;
    lim_pos = $signed(SUM_W'(gains.lim));
    lim_neg = -lim_pos;
    if (scaled > lim_pos) begin
      sat = lim_pos;
    end else if (scaled < lim_neg) begin
      sat = lim_neg;
    end else begin
      sat = scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      drive <= sat[OUT_W-1:0];
    end
  end

endmodule

// ----- rtl/six_axis_pid_wrench_top.sv -----
// Six-axis PID wrench controller: top level with handshake and stage control.
// Depends on sapw_pkg, sapw_cfg_regs and sapw_axis.
//
// The input channel carries one control tick per beat: a command bit and six
// signed Q8.16 pose errors. A step command produces one output beat with six
// saturated Q16.16 drive values; an abort clears every accumulator and
// previous error and produces no output beat.
// The block is a three-stage pipeline: the accumulator update, the gain
// products, then the sum, floor and saturation into the output register.
// A step accepted into the first stage passes through the product registers
// to the output register; one beat can be accepted in each unstalled cycle.
// Each stage advances when it is empty or the stage after it advances, so a
// stalled receiver holds the output register while the earlier stages fill;
// input ready drops only when all three stages hold a beat.
// Reset clears the gain and limit registers, the accumulators, the previous
// errors and all stage valid flags. The user must write registers through
// the plain write port while no beat is in flight; not enforced by the block.
module six_axis_pid_wrench_top import sapw_pkg::*; #(
  parameter int ACC_LIMIT_LINEAR  = 1048576,
  parameter int ACC_LIMIT_ANGULAR = 1048576
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    cmd,
  input  logic signed [ERR_W-1:0] error_x,
  input  logic signed [ERR_W-1:0] error_y,
  input  logic signed [ERR_W-1:0] error_z,
  input  logic signed [ERR_W-1:0] error_roll,
  input  logic signed [ERR_W-1:0] error_pitch,
  input  logic signed [ERR_W-1:0] error_yaw,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] force_x,
  output logic signed [OUT_W-1:0] force_y,
  output logic signed [OUT_W-1:0] force_z,
  output logic signed [OUT_W-1:0] torque_x,
  output logic signed [OUT_W-1:0] torque_y,
  output logic signed [OUT_W-1:0] torque_z
);

  gain_set_t               gains_linear;
  gain_set_t               gains_angular;
  stage_ctl_t              ctl;
  logic                    s1_valid;
  logic                    s2_valid;
  logic                    ready_s2;
  logic                    ready_out;
  logic                    in_beat;
  logic signed [ERR_W-1:0] err [NUM_AXES];
  logic signed [OUT_W-1:0] drive [NUM_AXES];

  sapw_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .linear    (gains_linear),
    .angular   (gains_angular)
  );

  assign ready_out = !out_valid || out_ready;
  assign ready_s2  = !s2_valid || ready_out;
  assign in_ready  = !s1_valid || ready_s2;
  assign in_beat   = in_valid && in_ready;

  assign ctl.load_s1  = in_beat && (cmd == CMD_STEP);
  assign ctl.clear    = in_beat && (cmd == CMD_ABORT);
  assign ctl.load_s2  = s1_valid && ready_s2;
  assign ctl.load_out = s2_valid && ready_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= ctl.load_s1;
      end
      if (ready_s2) begin
        s2_valid <= s1_valid;
      end
      if (ready_out) begin
        out_valid <= s2_valid;
      end
    end
  end

  assign err[0] = error_x;
  assign err[1] = error_y;
  assign err[2] = error_z;
  assign err[3] = error_roll;
  assign err[4] = error_pitch;
  assign err[5] = error_yaw;

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
    sapw_axis #(
      .AccLimit (i < NUM_LINEAR ? ACC_LIMIT_LINEAR : ACC_LIMIT_ANGULAR)
    ) u_axis (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .err   (err[i]),
      .gains (i < NUM_LINEAR ? gains_linear : gains_angular),
      .drive (drive[i])
    );
  end

  assign force_x  = drive[0];
  assign force_y  = drive[1];
  assign force_z  = drive[2];
  assign torque_x = drive[3];
  assign torque_y = drive[4];
  assign torque_z = drive[5];

  a_abort_no_beat: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> !s1_valid)
    else $error("abort beat entered the pipeline");

  a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while every stage is stalled");

  a_stage_two_to_output: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |=> out_valid)
    else $error("second stage advanced but output is not valid");

  a_step_reaches_stage_one: assert property (@(posedge clk) disable iff (rst)
    ctl.load_s1 |=> s1_valid)
    else $error("accepted step beat lost before the product stage");

endmodule

// ----- tb/six_axis_pid_wrench_top_tb.sv -----
// Self-checking testbench for six_axis_pid_wrench_top: a directed table, then random phases.
// Each output beat is checked against a row literal or this file's per-axis PID predictor.
// Depends on sapw_pkg and the six_axis_pid_wrench_top RTL.
`timescale 1ns / 100ps

module six_axis_pid_wrench_top_tb;
  import sapw_pkg::*;

  localparam int     ACC_LIM_LINEAR  = 1048576;
  localparam int     ACC_LIM_ANGULAR = 1048576;
  localparam int     CYCLE_LIMIT     = 400000;
  localparam int     IDLE_CYCLES     = 8;
  localparam int     NUM_PHASES      = 8;
  localparam int     BEATS_PER_PHASE = 104;
  localparam int     NUM_DIR_ROWS    = 41;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;
  localparam logic [ERR_W-1:0]     E_MAX         = 24'h7FFFFF;
  localparam logic [ERR_W-1:0]     E_MIN         = 24'h800000;
  localparam logic [ERR_W-1:0]     E_HALF        = 24'h080000;

  typedef logic [0:NUM_AXES-1][ERR_W-1:0] err_vec_t;
  typedef logic [0:NUM_AXES-1][OUT_W-1:0] wrench_t;
  typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic                   cmd;
    err_vec_t               errs;
    logic                   has_lit;
    wrench_t                lit;
  } dir_row_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic                    cmd;
  logic signed [ERR_W-1:0] error_x;
  logic signed [ERR_W-1:0] error_y;
  logic signed [ERR_W-1:0] error_z;
  logic signed [ERR_W-1:0] error_roll;
  logic signed [ERR_W-1:0] error_pitch;
  logic signed [ERR_W-1:0] error_yaw;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [OUT_W-1:0] force_x;
  logic signed [OUT_W-1:0] force_y;
  logic signed [OUT_W-1:0] force_z;
  logic signed [OUT_W-1:0] torque_x;
  logic signed [OUT_W-1:0] torque_y;
  logic signed [OUT_W-1:0] torque_z;

  logic [CFG_DATA_W-1:0] ctl_regs [8] = '{default: '0};
  longint                axis_acc [NUM_AXES] = '{default: 0};
  longint                axis_prev [NUM_AXES] = '{default: 0};
  wrench_t               pending_wrench [$];
  int                    mismatch_count = 0;
  int                    cycle_count = 0;
  string                 field_name [NUM_AXES] =
    '{"force_x", "force_y", "force_z", "torque_x", "torque_y", "torque_z"};

  dir_row_t dir_rows [NUM_DIR_ROWS] = '{
    '{ROW_BEAT,  '0, '0, CMD_STEP,  {6{E_MAX}}, 1'b1, '0},
    '{ROW_BEAT,  '0, '0, CMD_STEP,  {6{E_MIN}}, 1'b1, '0},
    '{ROW_BEAT,  '0, '0, CMD_ABORT, {6{E_MAX}}, 1'b0, '0},
    '{ROW_WRITE, REG_KP_LINEAR,    32'h0001_0000, CMD_STEP, '0, 1'b0, '0},
    '{ROW_WRITE, REG_KP_ANGULAR,   32'h0001_0000, CMD_STEP, '0, 1'b0, '0},
    '{ROW_WRITE, REG_FORCE_LIMIT,  32'h7FFF_FFFF, CMD_STEP, '0, 1'b0, '0},
    '{ROW_WRITE, REG_TORQUE_LIMIT, 32'hFFFF_FFFF, CMD_STEP, '0, 1'b0, '0},
    '{ROW_WRITE, REG_UNUSED_LO,    32'h1234_5678, CMD_STEP, '0, 1'b0, '0},
    '{ROW_WRITE, REG_UNUSED_HI,    32'hFFFF_FFFF, CMD_STEP, '0, 1'b0, '0},
    '{ROW_BEAT,  '0, '0, CMD_STEP,  {6{E_MAX}}, 1'b1, {6{32'h007F_FFFF}}},
    '{ROW_BEAT,  '0, '0, CMD_STEP,  {6{E_MIN}}, 1'b1, {6{32'hFF80_0000}}},
    '{ROW_BEAT,  '0, '0, CMD_STEP,
      {24'h000001, 24'hFFFFFF, 24'h000000, 24'h010000, 24'hFF0000, 24'h003039}, 1'b1,
      {32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_3039}},
    '{ROW_WRITE, REG_FORCE_LIMIT,  32'h0000_0100, CMD_STEP, '0, 1'b0, '0},
    '{ROW_WRITE, REG_TORQUE_LIMIT, 32'h0000_0000, CMD_STEP, '0, 1'b0, '0},
    '{ROW_BEAT,  '0, '0, CMD_STEP,  {6{E_MAX}}, 1'b1, {{3{32'h0000_0100}}, {3{32'h0}}}},
    '{ROW_BEAT,  '0, '0, CMD_STEP,  {6{E_MIN}}, 1'b1, {{3{32'hFFFF_FF00}}, {3{32'h0}}}},
    '{ROW_WRITE, REG_KP_LINEAR,    32'hFFFF_FFFF, CMD_STEP, '0, 1'b0, '0},
    '{ROW_WRITE, REG_KI_LINEAR,    32'hFFFF_FFFF, CMD_STEP, '0, 1'b0, '0},
    '{ROW_WRITE, REG_KD_LINEAR,    32'hFFFF_FFFF, CMD_STEP, '0, 1'b0, '0},
    '{ROW_WRITE, REG_KP_ANGULAR,   32'hFFFF_FFFF, CMD_STEP, '0, 1'b0, '0},
    '{ROW_WRITE, REG_KI_ANGULAR,   32'hFFFF_FFFF, CMD_STEP, '0, 1'b0, '0},
    '{ROW_WRITE, REG_KD_ANGULAR,   32'hFFFF_FFFF, CMD_STEP, '0, 1'b0, '0},
    '{ROW_WRITE, REG_FORCE_LIMIT,  32'h7FFF_FFFF, CMD_STEP, '0, 1'b0, '0},
    '{ROW_WRITE, REG_TORQUE_LIMIT, 32'h7FFF_FFFF, CMD_STEP, '0, 1'b0, '0},
    '{ROW_BEAT,  '0, '0, CMD_STEP,  {6{E_MAX}}, 1'b0, '0},
    '{ROW_BEAT,  '0, '0, CMD_STEP,  {6{E_MIN}}, 1'b0, '0},
    '{ROW_BEAT,  '0, '0, CMD_STEP,  {6{E_MAX}}, 1'b0, '0},
    '{ROW_BEAT,  '0, '0, CMD_ABORT, {6{E_MIN}}, 1'b0, '0},
    '{ROW_BEAT,  '0, '0, CMD_STEP,  {6{E_MIN}}, 1'b0, '0},
    '{ROW_WRITE, REG_KP_LINEAR,    32'h0000_0000, CMD_STEP, '0, 1'b0, '0},
    '{ROW_WRITE, REG_KI_LINEAR,    32'h0001_0000, CMD_STEP, '0, 1'b0, '0},
    '{ROW_WRITE, REG_KD_LINEAR,    32'h0000_0000, CMD_STEP, '0, 1'b0, '0},
    '{ROW_WRITE, REG_KP_ANGULAR,   32'h0000_0000, CMD_STEP, '0, 1'b0, '0},
    '{ROW_WRITE, REG_KI_ANGULAR,   32'h0000_0000, CMD_STEP, '0, 1'b0, '0},
    '{ROW_WRITE, REG_KD_ANGULAR,   32'h0001_0000, CMD_STEP, '0, 1'b0, '0},
    '{ROW_BEAT,  '0, '0, CMD_STEP,  {6{E_HALF}}, 1'b0, '0},
    '{ROW_BEAT,  '0, '0, CMD_STEP,  {6{E_HALF}}, 1'b0, '0},
    '{ROW_BEAT,  '0, '0, CMD_STEP,  {6{E_HALF}}, 1'b0, '0},
    '{ROW_BEAT,  '0, '0, CMD_STEP,
      {24'hF80000, 24'hF80000, 24'hF80000, E_MAX, E_MIN, 24'h000000}, 1'b0, '0},
    '{ROW_BEAT,  '0, '0, CMD_ABORT, {6{E_HALF}}, 1'b0, '0},
    '{ROW_BEAT,  '0, '0, CMD_STEP,  {6{E_MAX}}, 1'b0, '0}
  };

  six_axis_pid_wrench_top #(
    .ACC_LIMIT_LINEAR  (ACC_LIM_LINEAR),
    .ACC_LIMIT_ANGULAR (ACC_LIM_ANGULAR)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .error_x     (error_x),
    .error_y     (error_y),
    .error_z     (error_z),
    .error_roll  (error_roll),
    .error_pitch (error_pitch),
    .error_yaw   (error_yaw),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .force_x     (force_x),
    .force_y     (force_y),
    .force_z     (force_z),
    .torque_x    (torque_x),
    .torque_y    (torque_y),
    .torque_z    (torque_z)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic wrench_t compute_wrench(input err_vec_t errs);
    wrench_t w;
    int      a;
    bit      ang;
    longint  e, d, acc, acc_lim, kp, ki, kd, lim, drive;
    for (a = 0; a < NUM_AXES; a++) begin
      ang     = a >= NUM_LINEAR;
      acc_lim = longint'(ang ? ACC_LIM_ANGULAR : ACC_LIM_LINEAR);
      kp      = longint'(ctl_regs[ang ? REG_KP_ANGULAR : REG_KP_LINEAR]);
      ki      = longint'(ctl_regs[ang ? REG_KI_ANGULAR : REG_KI_LINEAR]);
      kd      = longint'(ctl_regs[ang ? REG_KD_ANGULAR : REG_KD_LINEAR]);
      lim     = longint'(ctl_regs[ang ? REG_TORQUE_LIMIT : REG_FORCE_LIMIT]);
      e       = longint'($signed(errs[a]));
      acc     = axis_acc[a] + e;
      if (acc > acc_lim) begin
        acc = acc_lim;
      end else if (acc < -acc_lim) begin
        acc = -acc_lim;
      end
      d = e - axis_prev[a];
      axis_acc[a]  = acc;
      axis_prev[a] = e;
      drive = (e * kp + acc * ki + d * kd) >>> FRAC_W;
      if (drive > lim) begin
        drive = lim;
      end else if (drive < -lim) begin
        drive = -lim;
      end
      w[a] = drive[OUT_W-1:0];
    end
    return w;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return $urandom_range(0, 32'h0003_0000);
      4: return $urandom_range(0, 32'h0000_0100);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000 | $urandom;
      3, 4: return $urandom_range(0, 32'h00FF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ERR_W-1:0] pick_error();
    int v;
    case ($urandom_range(0, 9))
      0: return E_MAX;
      1: return E_MIN;
      2: return '0;
      3, 4, 5: begin
        v = $urandom_range(0, 32'h0003_FFFF);
        if ($urandom_range(0, 1) == 1) v = -v;
        return v[ERR_W-1:0];
      end
      default: return ERR_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx <= REG_TORQUE_LIMIT) begin
      ctl_regs[idx] = (idx >= REG_FORCE_LIMIT) ? {1'b0, data[LIM_W-1:0]} : data;
    end
  endtask

  task automatic send_beat(input logic c, input err_vec_t e, input logic has_lit,
                           input wrench_t lit);
    wrench_t w;
    int      a;
    in_valid    <= 1'b1;
    cmd         <= c;
    error_x     <= e[0];
    error_y     <= e[1];
    error_z     <= e[2];
    error_roll  <= e[3];
    error_pitch <= e[4];
    error_yaw   <= e[5];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (c == CMD_ABORT) begin
      for (a = 0; a < NUM_AXES; a++) begin
        axis_acc[a]  = 0;
        axis_prev[a] = 0;
      end
    end else begin
      w = compute_wrench(e);
      pending_wrench.push_back(has_lit ? lit : w);
    end
  endtask

  task automatic wait_idle();
    while (pending_wrench.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("six_axis_pid_wrench_top_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin : out_monitor
    wrench_t got;
    wrench_t want;
    int      a;
    if (!rst && out_valid && out_ready) begin
      got = {force_x, force_y, force_z, torque_x, torque_y, torque_z};
      if (pending_wrench.size() == 0) begin
        report_mismatch("output beat with no pending wrench");
      end else begin
        want = pending_wrench.pop_front();
        for (a = 0; a < NUM_AXES; a++) begin
          if (got[a] !== want[a]) begin
            report_mismatch($sformatf("%s got %h want %h", field_name[a], got[a], want[a]));
          end
        end
      end
    end
  end

  initial begin : out_stall
    int mode;
    int len;
    int tick;
    out_ready <= 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(8, 80);
      repeat (len) begin
        @(posedge clk);
        tick++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= (tick % 5) != 3;
        endcase
      end
    end
  end

  initial begin : stimulus
    dir_row_t row;
    err_vec_t e;
    logic     c;
    int       r, a, phase, n, burst, k, gap;
    bit       smooth, paused;
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    cmd         <= CMD_STEP;
    error_x     <= '0;
    error_y     <= '0;
    error_z     <= '0;
    error_roll  <= '0;
    error_pitch <= '0;
    error_yaw   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < NUM_DIR_ROWS; r++) begin
      row = dir_rows[r];
      if (row.kind == ROW_WRITE) begin
        if (r == 0 || dir_rows[r-1].kind != ROW_WRITE) wait_idle();
        write_reg(row.idx, row.data);
        if (r == NUM_DIR_ROWS - 1 || dir_rows[r+1].kind != ROW_WRITE) cfg_we <= 1'b0;
      end else begin
        send_beat(row.cmd, row.errs, row.has_lit, row.lit);
        if (r == NUM_DIR_ROWS - 1 || dir_rows[r+1].kind != ROW_BEAT) in_valid <= 1'b0;
      end
    end

    e = '0;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      for (r = REG_KP_LINEAR; r <= REG_TORQUE_LIMIT; r++) begin
        write_reg(CFG_IDX_W'(r), (r >= REG_FORCE_LIMIT) ? pick_limit() : pick_gain());
      end
      if ($urandom_range(0, 2) == 0) begin
        write_reg(REG_UNUSED_LO + CFG_IDX_W'($urandom_range(0, 7)), $urandom);
      end
      cfg_we <= 1'b0;
      n      = 0;
      paused = 1'b0;
      while (n < BEATS_PER_PHASE) begin
        burst  = $urandom_range(1, 24);
        smooth = $urandom_range(0, 2) != 0;
        for (k = 0; k < burst && n < BEATS_PER_PHASE; k++) begin
          c = ($urandom_range(0, 99) < 6) ? CMD_ABORT : CMD_STEP;
          for (a = 0; a < NUM_AXES; a++) begin
            if (smooth) begin
              e[a] = e[a] + ERR_W'($urandom_range(0, 32'h1FFF)) - ERR_W'(32'h1000);
            end else begin
              e[a] = pick_error();
            end
          end
          send_beat(c, e, 1'b0, '0);
          n++;
        end
        case ($urandom_range(0, 9))
          0, 1, 2, 3: gap = 0;
          4, 5, 6, 7: gap = $urandom_range(1, 4);
          default: gap = $urandom_range(5, 12);
        endcase
        if (!paused && n >= BEATS_PER_PHASE / 2) begin
          if (gap == 0) gap = 1;
        end
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
          if (!paused && n >= BEATS_PER_PHASE / 2) begin
            paused = 1'b1;
            while (pending_wrench.size() != 0) @(posedge clk);
          end
        end
      end
      in_valid <= 1'b0;
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("six_axis_pid_wrench_top_tb passed");
    end else begin
      $display("six_axis_pid_wrench_top_tb failed");
    end
    $finish;
  end

endmodule

// ----- six_axis_pid_wrench_top.f -----
rtl/sapw_pkg.sv
rtl/sapw_cfg_regs.sv
rtl/sapw_axis.sv
rtl/six_axis_pid_wrench_top.sv
tb/six_axis_pid_wrench_top_tb.sv
